### rtl/core/gqg_pkg.sv
// Shared types, codes and helper functions for the glyph quad generator.
// Depends on nothing; the core, controller, datapath and divider refer to it by scoped names.

package gqg_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_START  = 2'd1,
        OP_LAYOUT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SCREEN_W = 2'd0,
        CFG_SCREEN_H = 2'd1,
        CFG_ATLAS_W  = 2'd2,
        CFG_ATLAS_H  = 2'd3
    } cfg_idx_t;

    // Which texture edge the shared divider is working on.
    typedef enum logic [1:0] {
        DIV_U0 = 2'd0,
        DIV_U1 = 2'd1,
        DIV_V0 = 2'd2,
        DIV_V1 = 2'd3
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_START_X,
        S_START_Y,
        S_START_FIN,
        S_LOOKUP,
        S_CHECK,
        S_MISS,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    // One glyph table entry, 64 bits.
    typedef struct packed {
        logic [11:0]        ax;
        logic [11:0]        ay;
        logic [7:0]         w;
        logic [7:0]         h;
        logic signed [7:0]  xo;
        logic signed [7:0]  yo;
        logic [7:0]         adv;
    } glyph_t;

    typedef struct packed {
        logic     capture;
        logic     tbl_write;
        logic     mul_x;
        logic     mul_y;
        logic     pen_y_load;
        logic     lookup;
        logic     geom;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     emit;
        logic     emit_miss;
        logic [2:0] corner;
        logic     advance;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic div_done;
        logic out_free;
    } status_t;

    localparam logic [2:0]  LAST_CORNER = 3'd5;
    localparam logic [16:0] TEX_ONE     = 17'd65536;
    localparam int          DIV_STEPS   = 9;     // two quotient bits per step
    localparam logic [13:0] SCREEN_W_RST = 14'd1280;
    localparam logic [13:0] SCREEN_H_RST = 14'd720;
    localparam logic [12:0] ATLAS_W_RST  = 13'd512;
    localparam logic [12:0] ATLAS_H_RST  = 13'd512;

    // Clamp a 26-bit two's complement value to the signed 24-bit range.
    function automatic logic [23:0] sat24(input logic [25:0] v);
        logic [23:0] r;
        if (!v[25] && (v[24:23] != 2'b00)) begin
            r = 24'h7FFFFF;
        end else if (v[25] && (v[24:23] != 2'b11)) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Corner k uses the right edge for corners 1, 2 and 4.
    function automatic logic corner_right(input logic [2:0] k);
        logic r;
        case (k)
            3'd1, 3'd2, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    // Corner k uses the bottom edge for corners 2, 4 and 5.
    function automatic logic corner_bottom(input logic [2:0] k);
        logic r;
        case (k)
            3'd2, 3'd4, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/gqg_if.sv
// Valid/ready channel interfaces for the glyph quad generator input and result streams.
// Depends on nothing; the payload fields are fixed by the item formats.

interface gqg_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [7:0]        char_code;
    logic [11:0]       atlas_x;
    logic [11:0]       atlas_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] draw_dx;
    logic signed [7:0] draw_dy;
    logic [7:0]        pen_step;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;

    modport source (
        output valid, opcode, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
               draw_dx, draw_dy, pen_step, pos_x, pos_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
               draw_dx, draw_dy, pen_step, pos_x, pos_y,
        output ready
    );
endinterface

interface gqg_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [2:0]         corner;
    logic               last_vertex;
    logic               missing_glyph;

    modport source (
        output valid, vertex_x, vertex_y, tex_u, tex_v, corner, last_vertex, missing_glyph,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, tex_u, tex_v, corner, last_vertex, missing_glyph,
        output ready
    );
endinterface

### rtl/core/glyph_quad_generator_core.sv
// Top level of the glyph quad generator: bitmap font text layout into textured quads.
// Depends on gqg_pkg, gqg_if, gqg_ctrl and gqg_datapath.
//
//   Channel  Dir  Handshake           Carries
//   in_ch    in   valid/ready         glyph write, string start or character layout item
//   out_ch   out  valid/ready         one vertex (or one missing-glyph marker)
//   cfg_*    in   write enable only   screen and atlas size registers, index 0..3
//
// A glyph write takes the write state; a string start the X and Y multiply states and
// a pen load (one shared multiplier, used once per axis); a missing glyph the lookup,
// check and marker states. A laid-out character takes lookup, geometry, four texture
// divisions on the single two-bit-per-cycle divider, then six vertices at one per
// cycle while the output is free; a saturating division (zero atlas size included)
// skips the iterative steps. Reset clears the glyph valid bits, pen and control state
// at once, no clearing pass. A stalled output holds the vertex and pauses the sequence.

module glyph_quad_generator_core #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    gqg_in_if.sink      in_ch,
    gqg_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    // The controller sequences each transaction; the datapath holds all values.
    gqg_pkg::cmd_t    cmd;
    gqg_pkg::status_t status;

    // Input transactions are taken only while the controller is idle, so the
    // captured item stays stable for the whole sequence it starts.
    gqg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath owns the glyph table (a memory of GLYPH_ENTRIES rows), the pen,
    // the divider and the output register, which lets the next input transaction be
    // accepted while the last vertex of a character still waits downstream.
    gqg_datapath #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .char_code    (in_ch.char_code),
        .atlas_x      (in_ch.atlas_x),
        .atlas_y      (in_ch.atlas_y),
        .glyph_width  (in_ch.glyph_width),
        .glyph_height (in_ch.glyph_height),
        .draw_dx      (in_ch.draw_dx),
        .draw_dy      (in_ch.draw_dy),
        .pen_step     (in_ch.pen_step),
        .pos_x        (in_ch.pos_x),
        .pos_y        (in_ch.pos_y),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ch       (out_ch)
    );

endmodule

### rtl/core/gqg_div.sv
// Iterative rounding divider for texture coordinates, two quotient bits per cycle.
// Depends on gqg_pkg for the step count and the saturation value.

module gqg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [12:0] numer,
    input  logic [12:0] denom,
    output logic        done,
    output logic [16:0] quot
);

    localparam int CNT_W = $clog2(gqg_pkg::DIV_STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [12:0]      rem_reg, rem_next;
    logic [17:0]      dvd_reg, dvd_next;
    logic [17:0]      quo_reg, quo_next;
    logic [12:0]      den_reg, den_next;

    logic [28:0] dividend;
    logic        too_big;
    logic [13:0] r1, r2;
    logic [12:0] r1n, r2n;
    logic        ge1, ge2;

    // Dividend is edge * 65536 + size / 2; a quotient of 2^17 or more saturates at once.
    always_comb
    begin
        dividend = {numer, 16'b0} + 29'(denom >> 1);
        too_big  = ({1'b0, dividend} >= {denom, 17'b0});
    end

    always_comb
    begin
        r1  = {rem_reg, dvd_reg[17]};
        ge1 = (r1 >= {1'b0, den_reg});
        r1n = ge1 ? 13'(r1 - {1'b0, den_reg}) : r1[12:0];
        r2  = {r1n, dvd_reg[16]};
        ge2 = (r2 >= {1'b0, den_reg});
        r2n = ge2 ? 13'(r2 - {1'b0, den_reg}) : r2[12:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            den_next = denom;
            if (too_big) begin
                quo_next  = {1'b0, gqg_pkg::TEX_ONE};
                done_next = 1'b1;
            end else begin
                rem_next  = {2'b00, dividend[28:18]};
                dvd_next  = dividend[17:0];
                quo_next  = '0;
                cnt_next  = CNT_W'(gqg_pkg::DIV_STEPS);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = r2n;
            dvd_next = {dvd_reg[15:0], 2'b00};
            quo_next = {quo_reg[15:0], ge1, ge2};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // The top quotient bit is always clear here; values above 1.0 clamp to 1.0.
    assign quot = (quo_reg[16:0] > gqg_pkg::TEX_ONE) ? gqg_pkg::TEX_ONE : quo_reg[16:0];
    assign done = done_reg;

endmodule

### rtl/core/gqg_ctrl.sv
// Controller state machine of the glyph quad generator.
// Depends on gqg_pkg for the state, opcode, command and status types.

module gqg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_opcode,
    output logic              in_ready,
    input  gqg_pkg::status_t  status,
    output gqg_pkg::cmd_t     cmd
);

    gqg_pkg::state_t   state_reg, state_next;
    gqg_pkg::div_sel_t sel_reg, sel_next;
    logic [2:0]        corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= gqg_pkg::S_IDLE;
            sel_reg    <= gqg_pkg::DIV_U0;
            corner_reg <= '0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        corner_next = corner_reg;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        cmd.corner  = corner_reg;
        in_ready    = 1'b0;
        case (state_reg)
            gqg_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    case (gqg_pkg::op_t'(in_opcode))
                        gqg_pkg::OP_WRITE:  state_next = gqg_pkg::S_WRITE;
                        gqg_pkg::OP_START:  state_next = gqg_pkg::S_START_X;
                        gqg_pkg::OP_LAYOUT: state_next = gqg_pkg::S_LOOKUP;
                        default:            state_next = gqg_pkg::S_IDLE;
                    endcase
                end
            end
            gqg_pkg::S_WRITE:
            begin
                cmd.tbl_write = 1'b1;
                state_next    = gqg_pkg::S_IDLE;
            end
            gqg_pkg::S_START_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = gqg_pkg::S_START_Y;
            end
            gqg_pkg::S_START_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = gqg_pkg::S_START_FIN;
            end
            gqg_pkg::S_START_FIN:
            begin
                cmd.pen_y_load = 1'b1;
                state_next     = gqg_pkg::S_IDLE;
            end
            gqg_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = gqg_pkg::S_CHECK;
            end
            gqg_pkg::S_CHECK:
            begin
                if (status.hit) begin
                    cmd.geom   = 1'b1;
                    sel_next   = gqg_pkg::DIV_U0;
                    state_next = gqg_pkg::S_DIV_GO;
                end else begin
                    state_next = gqg_pkg::S_MISS;
                end
            end
            gqg_pkg::S_MISS:
            begin
                if (status.out_free) begin
                    cmd.emit_miss = 1'b1;
                    state_next    = gqg_pkg::S_IDLE;
                end
            end
            gqg_pkg::S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = gqg_pkg::S_DIV_WAIT;
            end
            gqg_pkg::S_DIV_WAIT:
            begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    case (sel_reg)
                        gqg_pkg::DIV_U0:
                        begin
                            sel_next   = gqg_pkg::DIV_U1;
                            state_next = gqg_pkg::S_DIV_GO;
                        end
                        gqg_pkg::DIV_U1:
                        begin
                            sel_next   = gqg_pkg::DIV_V0;
                            state_next = gqg_pkg::S_DIV_GO;
                        end
                        gqg_pkg::DIV_V0:
                        begin
                            sel_next   = gqg_pkg::DIV_V1;
                            state_next = gqg_pkg::S_DIV_GO;
                        end
                        default:
                        begin
                            corner_next = '0;
                            state_next  = gqg_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            gqg_pkg::S_EMIT:
            begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (corner_reg == gqg_pkg::LAST_CORNER) begin
                        cmd.advance = 1'b1;
                        state_next  = gqg_pkg::S_IDLE;
                    end else begin
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = gqg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/gqg_datapath.sv
// Datapath of the glyph quad generator: configuration, glyph table, pen, geometry,
// texture divider and the output register. Depends on gqg_pkg, gqg_if and gqg_div.

module gqg_datapath #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gqg_pkg::cmd_t     cmd,
    output gqg_pkg::status_t  status,
    input  logic [7:0]        char_code,
    input  logic [11:0]       atlas_x,
    input  logic [11:0]       atlas_y,
    input  logic [7:0]        glyph_width,
    input  logic [7:0]        glyph_height,
    input  logic signed [7:0] draw_dx,
    input  logic signed [7:0] draw_dy,
    input  logic [7:0]        pen_step,
    input  logic [15:0]       pos_x,
    input  logic [15:0]       pos_y,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [13:0]       cfg_data,
    gqg_out_if.source         out_ch
);

    localparam int IDX_W   = $clog2(GLYPH_ENTRIES);
    // Character codes are eight bits, so no more than 256 entries can ever be marked.
    localparam int VALID_N = (GLYPH_ENTRIES < 256) ? GLYPH_ENTRIES : 256;
    localparam int VIDX_W  = $clog2(VALID_N);

    // Configuration registers.
    logic [13:0] sw_reg, sh_reg;
    logic [12:0] aw_reg, ah_reg;

    // Captured item.
    logic [7:0]      code_reg;
    gqg_pkg::glyph_t item_reg;
    logic [15:0]     pos_x_reg, pos_y_reg;

    // Glyph table and its valid bits.
    gqg_pkg::glyph_t     mem [GLYPH_ENTRIES];
    gqg_pkg::glyph_t     rd_reg;
    logic [VALID_N-1:0]  valid_reg;
    logic                hit_reg;

    // Pen and start-position product.
    logic [23:0] pen_x_reg, pen_y_reg;
    logic [29:0] prod_reg;
    logic [29:0] prod_rnd;

    // Quad geometry and texture coordinates.
    logic [23:0] xs0_reg, xs1_reg, ys0_reg, ys1_reg;
    logic [16:0] u0_reg, u1_reg, v0_reg, v1_reg;
    logic [25:0] left_sum, right_sum, top_sum, bottom_sum, adv_sum;

    // Output register.
    logic               out_valid_reg;
    logic [23:0]        vx_reg, vy_reg;
    logic [16:0]        tu_reg, tv_reg;
    logic [2:0]         corner_reg;
    logic               last_reg, miss_reg;

    logic [IDX_W+7:0] code_wide;
    logic [IDX_W-1:0] idx;
    logic [VIDX_W-1:0] vidx;
    logic             in_range;

    logic        div_done;
    logic [16:0] div_quot;
    logic [12:0] div_numer, div_denom;
    logic        right_sel, bottom_sel;

    assign code_wide = {{IDX_W{1'b0}}, code_reg};
    assign idx       = code_wide[IDX_W-1:0];
    assign vidx      = code_wide[VIDX_W-1:0];
    assign in_range  = (32'(code_reg) < GLYPH_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sw_reg <= gqg_pkg::SCREEN_W_RST;
            sh_reg <= gqg_pkg::SCREEN_H_RST;
            aw_reg <= gqg_pkg::ATLAS_W_RST;
            ah_reg <= gqg_pkg::ATLAS_H_RST;
        end else if (cfg_we) begin
            case (gqg_pkg::cfg_idx_t'(cfg_index))
                gqg_pkg::CFG_SCREEN_W: sw_reg <= cfg_data;
                gqg_pkg::CFG_SCREEN_H: sh_reg <= cfg_data;
                gqg_pkg::CFG_ATLAS_W:  aw_reg <= cfg_data[12:0];
                gqg_pkg::CFG_ATLAS_H:  ah_reg <= cfg_data[12:0];
                default:               sw_reg <= sw_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            code_reg     <= char_code;
            item_reg.ax  <= atlas_x;
            item_reg.ay  <= atlas_y;
            item_reg.w   <= glyph_width;
            item_reg.h   <= glyph_height;
            item_reg.xo  <= draw_dx;
            item_reg.yo  <= draw_dy;
            item_reg.adv <= pen_step;
            pos_x_reg    <= pos_x;
            pos_y_reg    <= pos_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write && in_range) begin
            mem[idx] <= item_reg;
        end
        if (cmd.lookup) begin
            rd_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (cmd.tbl_write && in_range) begin
                valid_reg[vidx] <= 1'b1;
            end
            if (cmd.lookup) begin
                hit_reg <= in_range && valid_reg[vidx];
            end
        end
    end

    // Start position: one product per cycle, then round to nearest Q15.8.
    assign prod_rnd = prod_reg + 30'd128;
    assign adv_sum  = {2'b00, pen_x_reg} + {10'b0, rd_reg.adv, 8'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else begin
            if (cmd.mul_y) begin
                pen_x_reg <= {2'b00, prod_rnd[29:8]};
            end else if (cmd.advance) begin
                pen_x_reg <= gqg_pkg::sat24(adv_sum);
            end
            if (cmd.pen_y_load) begin
                pen_y_reg <= {2'b00, prod_rnd[29:8]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_x) begin
            prod_reg <= 30'(sw_reg) * 30'(pos_x_reg);
        end else if (cmd.mul_y) begin
            prod_reg <= 30'(sh_reg) * 30'(pos_y_reg);
        end
    end

    // Quad edges in Q15.8; the far edge builds on the unclamped near edge.
    always_comb
    begin
        left_sum   = {{2{pen_x_reg[23]}}, pen_x_reg} + {{10{rd_reg.xo[7]}}, rd_reg.xo, 8'b0};
        right_sum  = left_sum + {10'b0, rd_reg.w, 8'b0};
        top_sum    = {{2{pen_y_reg[23]}}, pen_y_reg} + {{10{rd_reg.yo[7]}}, rd_reg.yo, 8'b0};
        bottom_sum = top_sum + {10'b0, rd_reg.h, 8'b0};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geom) begin
            xs0_reg <= gqg_pkg::sat24(left_sum);
            xs1_reg <= gqg_pkg::sat24(right_sum);
            ys0_reg <= gqg_pkg::sat24(top_sum);
            ys1_reg <= gqg_pkg::sat24(bottom_sum);
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            gqg_pkg::DIV_U0:
            begin
                div_numer = {1'b0, rd_reg.ax};
                div_denom = aw_reg;
            end
            gqg_pkg::DIV_U1:
            begin
                div_numer = {1'b0, rd_reg.ax} + {5'b0, rd_reg.w};
                div_denom = aw_reg;
            end
            gqg_pkg::DIV_V0:
            begin
                div_numer = {1'b0, rd_reg.ay};
                div_denom = ah_reg;
            end
            default:
            begin
                div_numer = {1'b0, rd_reg.ay} + {5'b0, rd_reg.h};
                div_denom = ah_reg;
            end
        endcase
    end

    gqg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_store) begin
            case (cmd.div_sel)
                gqg_pkg::DIV_U0: u0_reg <= div_quot;
                gqg_pkg::DIV_U1: u1_reg <= div_quot;
                gqg_pkg::DIV_V0: v0_reg <= div_quot;
                default:         v1_reg <= div_quot;
            endcase
        end
    end

    // Output register.
    assign right_sel  = gqg_pkg::corner_right(cmd.corner);
    assign bottom_sel = gqg_pkg::corner_bottom(cmd.corner);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_miss) begin
            out_valid_reg <= 1'b1;
        end else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            vx_reg     <= right_sel ? xs1_reg : xs0_reg;
            vy_reg     <= bottom_sel ? ys1_reg : ys0_reg;
            tu_reg     <= right_sel ? u1_reg : u0_reg;
            tv_reg     <= bottom_sel ? v1_reg : v0_reg;
            corner_reg <= cmd.corner;
            last_reg   <= (cmd.corner == gqg_pkg::LAST_CORNER);
            miss_reg   <= 1'b0;
        end else if (cmd.emit_miss) begin
            vx_reg     <= '0;
            vy_reg     <= '0;
            tu_reg     <= '0;
            tv_reg     <= '0;
            corner_reg <= '0;
            last_reg   <= 1'b1;
            miss_reg   <= 1'b1;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.vertex_x      = $signed(vx_reg);
    assign out_ch.vertex_y      = $signed(vy_reg);
    assign out_ch.tex_u         = tu_reg;
    assign out_ch.tex_v         = tv_reg;
    assign out_ch.corner        = corner_reg;
    assign out_ch.last_vertex   = last_reg;
    assign out_ch.missing_glyph = miss_reg;

    assign status.hit      = hit_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ch.ready;

endmodule

### rtl/core/gqg_checker.sv
// Port-level checker for the glyph quad generator, bound to the top level.
// Depends only on the top level's ports.

module gqg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [23:0] vertex_x,
    input logic signed [23:0] vertex_y,
    input logic [16:0]        tex_u,
    input logic [16:0]        tex_v,
    input logic [2:0]         corner,
    input logic               last_vertex,
    input logic               missing_glyph
);

    // A stalled vertex keeps its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y))
        else $error("stalled vertex changed");

    // Only the sixth corner or a missing-glyph marker closes a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_vertex |-> (corner == 3'd5) || missing_glyph)
        else $error("last_vertex on a corner other than the last");

    // A missing-glyph marker carries zeros and ends the character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && missing_glyph |-> last_vertex && (corner == 3'd0) &&
            (vertex_x == 24'sd0) && (vertex_y == 24'sd0) && (tex_u == 17'd0) &&
            (tex_v == 17'd0))
        else $error("missing-glyph marker with nonzero fields");

    // Texture coordinates never exceed 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
        else $error("texture coordinate above 1.0");

    // While a character is only partly delivered, no new transaction is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_vertex |-> !in_ready)
        else $error("input accepted in the middle of a character");

endmodule

bind glyph_quad_generator_core gqg_checker u_gqg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .vertex_x      (out_ch.vertex_x),
    .vertex_y      (out_ch.vertex_y),
    .tex_u         (out_ch.tex_u),
    .tex_v         (out_ch.tex_v),
    .corner        (out_ch.corner),
    .last_vertex   (out_ch.last_vertex),
    .missing_glyph (out_ch.missing_glyph)
);

### sim/gqg_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the glyph quad generator: watches both channels and the register port.
// Depends on gqg_pkg and gqg_if; keeps its own glyph table, pen and register copies.

module gqg_scoreboard #(
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    gqg_in_if           in_ch,
    gqg_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    import gqg_pkg::*;

    typedef struct packed {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [2:0]         corner;
        logic               last;
        logic               miss;
    } vertex_t;

    // Corners 1, 2 and 4 take the right edge; corners 2, 4 and 5 take the bottom edge.
    localparam logic [5:0] RIGHT_CORNERS  = 6'b010110;
    localparam logic [5:0] BOTTOM_CORNERS = 6'b110100;

    vertex_t            vertex_q[$];
    glyph_t             glyphs[ENTRIES];
    logic               glyph_known[ENTRIES];
    logic signed [23:0] pen_x;
    logic signed [23:0] pen_y;
    logic [13:0]        scr_w;
    logic [13:0]        scr_h;
    logic [12:0]        atl_w;
    logic [12:0]        atl_h;
    int                 bad_count;

    function automatic logic signed [23:0] clamp24(input longint v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Q1.16 fraction of the atlas, rounded to nearest and capped at 1.0.
    function automatic logic [16:0] tex_coord(input int unsigned edge_px,
                                              input int unsigned size);
        longint q;
        if (size == 0) begin
            return TEX_ONE;
        end
        q = ((longint'(edge_px) << 16) + longint'(size >> 1)) / longint'(size);
        return (q > 65536) ? TEX_ONE : q[16:0];
    endfunction

    // Start position in Q15.8 pixels, rounded with halves upward.
    function automatic logic signed [23:0] start_pen(input logic [13:0] size,
                                                     input logic [15:0] frac);
        longint prod;
        prod = longint'(size) * longint'(frac);
        return clamp24((prod + 128) >>> 8);
    endfunction

    task automatic queue_quad(input int code);
        glyph_t             g;
        vertex_t            vtx;
        longint             left;
        longint             top;
        logic signed [23:0] xl, xr, yt, yb;
        logic [16:0]        u0, u1, v0, v1;
        if (code >= ENTRIES || !glyph_known[code]) begin
            vtx = '0;
            vtx.last = 1'b1;
            vtx.miss = 1'b1;
            vertex_q.insert(vertex_q.size(), vtx);
            return;
        end
        g    = glyphs[code];
        left = longint'(pen_x) + longint'($signed(g.xo)) * 256;
        top  = longint'(pen_y) + longint'($signed(g.yo)) * 256;
        xl   = clamp24(left);
        xr   = clamp24(left + longint'(g.w) * 256);
        yt   = clamp24(top);
        yb   = clamp24(top + longint'(g.h) * 256);
        u0   = tex_coord(int'(g.ax), int'(atl_w));
        u1   = tex_coord(int'(g.ax) + int'(g.w), int'(atl_w));
        v0   = tex_coord(int'(g.ay), int'(atl_h));
        v1   = tex_coord(int'(g.ay) + int'(g.h), int'(atl_h));
        for (int k = 0; k < 6; k++) begin
            vtx.vx     = RIGHT_CORNERS[k] ? xr : xl;
            vtx.vy     = BOTTOM_CORNERS[k] ? yb : yt;
            vtx.u      = RIGHT_CORNERS[k] ? u1 : u0;
            vtx.v      = BOTTOM_CORNERS[k] ? v1 : v0;
            vtx.corner = 3'(k);
            vtx.last   = (k == 5);
            vtx.miss   = 1'b0;
            vertex_q.insert(vertex_q.size(), vtx);
        end
        pen_x = clamp24(longint'(pen_x) + longint'(g.adv) * 256);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        vertex_t got;
        vertex_t want;
        glyph_t  g;
        if (!rst_n) begin
            vertex_q.delete();
            foreach (glyph_known[i]) begin
                glyph_known[i] = 1'b0;
            end
            pen_x      = '0;
            pen_y      = '0;
            scr_w      = SCREEN_W_RST;
            scr_h      = SCREEN_H_RST;
            atl_w      = ATLAS_W_RST;
            atl_h      = ATLAS_H_RST;
            bad_count  = 0;
            mismatches <= 0;
            pending    <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_W: scr_w = cfg_data;
                    CFG_SCREEN_H: scr_h = cfg_data;
                    CFG_ATLAS_W:  atl_w = cfg_data[12:0];
                    CFG_ATLAS_H:  atl_h = cfg_data[12:0];
                    default: ;
                endcase
            end

            if (out_ch.valid && out_ch.ready) begin
                got.vx     = out_ch.vertex_x;
                got.vy     = out_ch.vertex_y;
                got.u      = out_ch.tex_u;
                got.v      = out_ch.tex_v;
                got.corner = out_ch.corner;
                got.last   = out_ch.last_vertex;
                got.miss   = out_ch.missing_glyph;
                if (vertex_q.size() == 0) begin
                    if (bad_count < 10) begin
                        $display("%0t: vertex with nothing outstanding: x=%0d y=%0d corner=%0d",
                                 $realtime, got.vx, got.vy, got.corner);
                    end
                    bad_count++;
                end else begin
                    want = vertex_q.pop_front();
                    if (got.vx !== want.vx || got.vy !== want.vy || got.u !== want.u ||
                        got.v !== want.v || got.corner !== want.corner ||
                        got.last !== want.last || got.miss !== want.miss) begin
                        if (bad_count < 10) begin
                            $display("%0t: vertex mismatch", $realtime);
                            $display("  expected x=%0d y=%0d u=%0d v=%0d corner=%0d last=%0b miss=%0b",
                                     want.vx, want.vy, want.u, want.v, want.corner,
                                     want.last, want.miss);
                            $display("  actual   x=%0d y=%0d u=%0d v=%0d corner=%0d last=%0b miss=%0b",
                                     got.vx, got.vy, got.u, got.v, got.corner,
                                     got.last, got.miss);
                        end
                        bad_count++;
                    end
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                case (op_t'(in_ch.opcode))
                    OP_WRITE: begin
                        if (int'(in_ch.char_code) < ENTRIES) begin
                            g.ax  = in_ch.atlas_x;
                            g.ay  = in_ch.atlas_y;
                            g.w   = in_ch.glyph_width;
                            g.h   = in_ch.glyph_height;
                            g.xo  = in_ch.draw_dx;
                            g.yo  = in_ch.draw_dy;
                            g.adv = in_ch.pen_step;
                            glyphs[in_ch.char_code]      = g;
                            glyph_known[in_ch.char_code] = 1'b1;
                        end
                    end
                    OP_START: begin
                        pen_x = start_pen(scr_w, in_ch.pos_x);
                        pen_y = start_pen(scr_h, in_ch.pos_y);
                    end
                    OP_LAYOUT: queue_quad(int'(in_ch.char_code));
                    default: ;
                endcase
            end

            mismatches <= bad_count;
            pending    <= vertex_q.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the glyph quad generator: clock, reset, stimulus and verdict.
// Depends on gqg_pkg, gqg_if, glyph_quad_generator_core and gqg_scoreboard.

module tb_top;
    import gqg_pkg::*;

    // One input transaction as the stimulus sees it. Fields that the opcode does not use
    // still carry random values, so the block is shown noise on every unused bit.
    typedef struct {
        op_t               op;
        logic [7:0]        code;
        logic [11:0]       ax;
        logic [11:0]       ay;
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] xo;
        logic signed [7:0] yo;
        logic [7:0]        adv;
        logic [15:0]       px;
        logic [15:0]       py;
    } text_cmd_t;

    // Cycles to let pass after the last vertex before touching the registers or ending.
    // A start or a glyph write that follows the last layout keeps the block busy
    // without producing anything.
    localparam int QUIET_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;
    int          mismatches;
    int          pending;

    // When set, both sides run without gaps; used to get back-to-back stretches.
    bit          calm;
    // One-shot request for the receiver to hold off long enough to back up the input.
    bit          hold_long;

    logic [7:0]  written_codes[$];

    gqg_in_if  in_ch();
    gqg_out_if out_ch();

    glyph_quad_generator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gqg_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    // Watchdog. The slowest correct run ends well before this timeout even with every
    // vertex stalled the longest random gap, so reaching it means the block has hung.
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic text_cmd_t random_cmd();
        text_cmd_t c;
        c.op   = op_t'($urandom_range(0, 3));
        c.code = 8'($urandom);
        c.ax   = 12'($urandom);
        c.ay   = 12'($urandom);
        c.w    = 8'($urandom);
        c.h    = 8'($urandom);
        c.xo   = 8'($urandom);
        c.yo   = 8'($urandom);
        c.adv  = 8'($urandom);
        c.px   = 16'($urandom);
        c.py   = 16'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] pick_written();
        return written_codes[$urandom_range(0, written_codes.size() - 1)];
    endfunction

    // Offers one transaction after a random gap and returns at the falling edge after
    // it is taken. Valid stays high on return, so a zero gap next time leaves it high.
    task automatic send(input text_cmd_t c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= c.op;
        in_ch.char_code    <= c.code;
        in_ch.atlas_x      <= c.ax;
        in_ch.atlas_y      <= c.ay;
        in_ch.glyph_width  <= c.w;
        in_ch.glyph_height <= c.h;
        in_ch.draw_dx      <= c.xo;
        in_ch.draw_dy      <= c.yo;
        in_ch.pen_step     <= c.adv;
        in_ch.pos_x        <= c.px;
        in_ch.pos_y        <= c.py;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_glyph(input logic [7:0] code, input logic [11:0] ax,
                               input logic [11:0] ay, input logic [7:0] w,
                               input logic [7:0] h, input logic signed [7:0] xo,
                               input logic signed [7:0] yo, input logic [7:0] adv);
        text_cmd_t c;
        c      = random_cmd();
        c.op   = OP_WRITE;
        c.code = code;
        c.ax   = ax;
        c.ay   = ay;
        c.w    = w;
        c.h    = h;
        c.xo   = xo;
        c.yo   = yo;
        c.adv  = adv;
        written_codes.insert(written_codes.size(), code);
        send(c);
    endtask

    task automatic start_at(input logic [15:0] px, input logic [15:0] py);
        text_cmd_t c;
        c    = random_cmd();
        c.op = OP_START;
        c.px = px;
        c.py = py;
        send(c);
    endtask

    task automatic lay_out(input logic [7:0] code);
        text_cmd_t c;
        c      = random_cmd();
        c.op   = OP_LAYOUT;
        c.code = code;
        send(c);
    endtask

    // Waits until every predicted vertex has come out, then lets the block finish any
    // quiet work so that the registers can be changed safely.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // Writes all four registers on consecutive cycles; the block is idle here.
    task automatic configure(input logic [13:0] sw, input logic [13:0] sh,
                             input logic [12:0] aw, input logic [12:0] ah);
        cfg_idx_t idx[4];
        logic [13:0] val[4];
        idx = '{CFG_SCREEN_W, CFG_SCREEN_H, CFG_ATLAS_W, CFG_ATLAS_H};
        val = '{sw, sh, {1'b0, aw}, {1'b0, ah}};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed text: glyph definitions, a pen placement and then a short
    // string of characters, most of them defined. Unused opcodes are mixed in as
    // noise and do not count toward the item budget.
    task automatic run_text(input int n_items);
        int done;
        int pick;
        int len;
        text_cmd_t c;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                c    = random_cmd();
                c.op = OP_NONE;
                send(c);
            end else if (pick < 25) begin
                c = random_cmd();
                write_glyph(c.code, c.ax, c.ay, c.w, c.h, c.xo, c.yo, c.adv);
                done++;
            end else if (pick < 35) begin
                start_at(16'($urandom), 16'($urandom));
                done++;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    lay_out(($urandom_range(0, 9) != 0) ? pick_written() : 8'($urandom));
                    done++;
                end
            end
        end
    endtask

    // Result side: before each vertex it stalls a random number of cycles, and once
    // on request it holds off for a long stretch so the block backs up into its input.
    initial begin : receiver
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_long) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_long = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 17);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!out_ch.valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        text_cmd_t c;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SCREEN_W;
        cfg_data           = '0;
        calm               = 1'b0;
        hold_long          = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_NONE;
        in_ch.char_code    = '0;
        in_ch.atlas_x      = '0;
        in_ch.atlas_y      = '0;
        in_ch.glyph_width  = '0;
        in_ch.glyph_height = '0;
        in_ch.draw_dx      = '0;
        in_ch.draw_dy      = '0;
        in_ch.pen_step     = '0;
        in_ch.pos_x        = '0;
        in_ch.pos_y        = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset register values.
        // A character looked up before anything is defined is a missing glyph.
        lay_out(8'd65);
        // An unused opcode must be swallowed without a result.
        c    = random_cmd();
        c.op = OP_NONE;
        send(c);
        // Smallest glyph with the most negative offsets (8'h80 is -128).
        write_glyph(8'd65, 12'd0, 12'd0, 8'd0, 8'd0, 8'h80, 8'h80, 8'd0);
        start_at(16'h0000, 16'h0000);
        lay_out(8'd65);
        // Largest glyph at the far atlas corner: every texture edge saturates.
        write_glyph(8'd255, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'h7F, 8'h7F, 8'd255);
        start_at(16'hFFFF, 16'hFFFF);
        lay_out(8'd255);
        lay_out(8'd255);
        // An ordinary glyph at code zero, placed at half and at the smallest step.
        write_glyph(8'd0, 12'd100, 12'd200, 8'd12, 8'd16, -8'sd2, 8'sd3, 8'd9);
        lay_out(8'd0);
        start_at(16'h8000, 16'h8000);
        lay_out(8'd0);
        start_at(16'h0001, 16'h0001);
        lay_out(8'd0);
        lay_out(8'd1);
        // Redefining an entry replaces it; texture edge just inside the atlas.
        write_glyph(8'd0, 12'd511, 12'd0, 8'd1, 8'd1, 8'sd0, 8'sd0, 8'd1);
        lay_out(8'd0);
        settle();

        // Largest sizes of the random phases. A long run of wide glyphs walks the pen up to its
        // ceiling, so the pen and the right edge both saturate.
        configure(14'd8192, 14'd8192, 13'd4096, 13'd4096);
        write_glyph(8'd200, 12'd4000, 12'd96, 8'd255, 8'd255, 8'h7F, 8'h81, 8'd255);
        start_at(16'hFFFF, 16'hFFFF);
        calm = 1'b1;
        repeat (100) begin
            lay_out(($urandom_range(0, 7) == 0) ? pick_written() : 8'd200);
        end
        calm = 1'b0;
        settle();

        // Smallest sizes: almost every texture coordinate saturates.
        configure(14'd1, 14'd1, 13'd1, 13'd1);
        run_text(15);
        settle();

        // Zero atlas size on both axes.
        configure(14'd640, 14'd480, 13'd0, 13'd0);
        run_text(15);
        settle();

        // Random sizes. The first of these phases also backs the block up against a
        // long receiver hold-off while the sender keeps offering transactions.
        for (int phase = 0; phase < 3; phase++) begin
            configure(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                      13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
            hold_long = (phase == 0);
            calm      = (phase == 1);
            run_text(15);
            settle();
        end
        calm = 1'b0;

        if (mismatches == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
